// ===== hdl/min_width_bit_unpacker_defines.svh =====
// assertion helpers shared by the unpacker modules
`ifndef MIN_WIDTH_BIT_UNPACKER_DEFINES_SVH
`define MIN_WIDTH_BIT_UNPACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define MWBU_ASSERT(lbl, c, r, prop) \
  lbl: assert property (@(posedge c) disable iff (r) prop) \
    else $error("mwbu assertion failed");

// checked on every edge, reset included
`define MWBU_ASSERT_ALWAYS(lbl, c, prop) \
  lbl: assert property (@(posedge c) prop) \
    else $error("mwbu assertion failed");

`else

`define MWBU_ASSERT(lbl, c, r, prop)
`define MWBU_ASSERT_ALWAYS(lbl, c, prop)

`endif

`endif

// ===== hdl/mwbu_pkg.sv =====
`default_nettype none

package mwbu_pkg;

  localparam logic [7:0] HDR_TAIL_MASK  = 8'hE0;
  localparam logic [7:0] HDR_WIDTH_MASK = 8'h1F;
  localparam int         HDR_TAIL_SHIFT = 5;

  localparam logic [3:0] BYTE_BITS = 4'd8;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        final_of_run;
  } word_item_t;

  // one data byte, classified by the front end
  typedef struct packed {
    logic [7:0] data;   // bits still to consume, left aligned
    logic [3:0] nbits;  // 1..8 bits to take from data
    logic [5:0] width;  // word width of the message, 1..32
    logic       last;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/mwbu_front.sv =====
`default_nettype none

module mwbu_front
  import mwbu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire byte_item_t byte_item,
  input  wire logic       q_full,
  output logic            push,
  output job_t            push_job
);

  logic       expect_header;
  logic [5:0] word_width;
  logic [3:0] tail_bits;

  logic       accept;
  logic [2:0] hdr_tail;
  logic [4:0] hdr_width;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  assign hdr_tail  = 3'((byte_item.in_byte & HDR_TAIL_MASK) >> HDR_TAIL_SHIFT);
  assign hdr_width = 5'(byte_item.in_byte & HDR_WIDTH_MASK);

  assign push           = accept && !expect_header;
  assign push_job.data  = byte_item.in_byte;
  assign push_job.nbits = byte_item.last_byte ? tail_bits : BYTE_BITS;
  assign push_job.width = word_width;
  assign push_job.last  = byte_item.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      word_width    <= 6'd1;
      tail_bits     <= BYTE_BITS;
    end else if (accept) begin
      if (expect_header) begin
        tail_bits     <= (hdr_tail == 3'd0) ? BYTE_BITS : {1'b0, hdr_tail};
        word_width    <= {1'b0, hdr_width} + 6'd1;
        expect_header <= byte_item.last_byte;
      end else if (byte_item.last_byte) begin
        expect_header <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mwbu_queue.sv =====
`default_nettype none

`include "min_width_bit_unpacker_defines.svh"

module mwbu_queue
  import mwbu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output job_t      q_job
);

  job_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MWBU_ASSERT(a_no_overflow, clk, rst, full |-> !push)
  `MWBU_ASSERT(a_no_underflow, clk, rst, !q_valid |-> !pop)
  `MWBU_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (count == '0))

endmodule

`default_nettype wire

// ===== hdl/mwbu_back.sv =====
`default_nettype none

`include "min_width_bit_unpacker_defines.svh"

module mwbu_back
  import mwbu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  wire job_t   q_job,
  output logic        pop,
  output logic        word_valid,
  input  wire logic   word_stall,
  output word_item_t  word_item
);

  job_t        cur;
  logic        cur_valid;
  logic [31:0] acc;
  logic [5:0]  cnt;

  logic        adv;
  logic        step;
  logic        done;
  logic        full;
  logic [5:0]  room;
  logic [3:0]  take;
  logic [3:0]  rem_left;
  logic [5:0]  cnt_sum;
  logic [31:0] acc_next;

  assign adv  = !word_valid || !word_stall;
  assign step = cur_valid && adv;

  // take as many bits as fit in the current word, at most what the byte has
  assign room     = cur.width - cnt;
  assign take     = (room < {2'b0, cur.nbits}) ? room[3:0] : cur.nbits;
  assign acc_next = (acc << take) | (32'(cur.data) >> (BYTE_BITS - take));
  assign cnt_sum  = cnt + {2'b0, take};
  assign full     = (cnt_sum == cur.width);
  assign rem_left = cur.nbits - take;

  assign done = step && (rem_left == 4'd0);
  assign pop  = q_valid && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      acc        <= '0;
      cnt        <= '0;
      word_valid <= 1'b0;
    end else begin
      if (adv) begin
        word_valid <= step && full;
      end
      if (step) begin
        if (full || (done && cur.last)) begin
          acc <= '0;
          cnt <= '0;
        end else begin
          acc <= acc_next;
          cnt <= cnt_sum;
        end
      end
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && full) begin
      word_item.word         <= acc_next;
      // leftover bits too few for another word
      word_item.final_of_run <= ({2'b0, rem_left} < cur.width);
    end
    if (pop) begin
      cur <= q_job;
    end else if (step) begin
      cur.data  <= cur.data << take;
      cur.nbits <= rem_left;
    end
  end

  `MWBU_ASSERT(a_cnt_below_width, clk, rst, cur_valid |-> (cnt < cur.width))
  `MWBU_ASSERT(a_bits_pending, clk, rst, cur_valid |-> (cur.nbits != 4'd0))
  `MWBU_ASSERT(a_emit_needs_step, clk, rst,
    ($rose(word_valid)) |-> $past(cur_valid))

endmodule

`default_nettype wire

// ===== hdl/min_width_bit_unpacker.sv =====
// channel  dir  handshake                payload
// byte     in   byte_valid / byte_stall  byte_item (in_byte, last_byte)
// word     out  word_valid / word_stall  word_item (word, final_of_run)
//
// one byte accepted per cycle while the 4-entry job queue has room
// the back end works through a data byte in steps, each completing a word or
// using up the bits that remain; header bytes never reach the back end
// a byte goes via the job queue and back-end byte register to the registered word output
// rst is synchronous: queue empty, next byte is a header
// word_stall holds the output register and back end; byte_stall rises when the queue fills
`default_nettype none

module min_width_bit_unpacker
  import mwbu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire byte_item_t byte_item,
  output logic            word_valid,
  input  wire logic       word_stall,
  output word_item_t      word_item
);

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic q_valid;
  job_t q_job;

  mwbu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  mwbu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  mwbu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word_item  (word_item)
  );

endmodule

`default_nettype wire
